// ----- sv/w26ra_pkg.sv -----
// Shared types and constants for the 2/6 wavelet row analysis block.
// Used by every module of the block; depends on nothing else.
package w26ra_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int MAX_ROW_WIDTH = 4096;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int IDX_W         = 11;
    localparam int WIN_N         = 6;
    localparam int SHIFT_W       = 2;
    localparam int RND_W         = 3;
    localparam int ACC_W         = 21;
    localparam int HP_SHIFT      = 3;

    localparam int JOBQ_DEPTH = 4;
    localparam int JOBQ_AW    = $clog2(JOBQ_DEPTH);
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);

    localparam logic [COL_W-1:0] COL_LAST       = COL_W'(MAX_ROW_WIDTH - 1);
    localparam logic [COL_W-1:0] COL_FIRST_PAIR = COL_W'(5);

    localparam logic signed [ACC_W-1:0] HP_ROUND = ACC_W'(4);
    localparam logic signed [ACC_W-1:0] HP_MAX   = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] HP_MIN   = -ACC_W'(32768);

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef struct packed {
        t_sample sample;
        logic    row_end;
    } t_in_item;

    typedef struct packed {
        t_sample          low_coef;
        t_sample          high_coef;
        logic [IDX_W-1:0] coef_index;
        logic             row_done;
        logic             run_last;
        logic             row_error;
    } t_out_item;

    // Filter operations in the order a job runs through them.
    typedef enum logic [1:0] {
        OP_LEFT  = 2'd0,
        OP_INNER = 2'd1,
        OP_RIGHT = 2'd2,
        OP_ERR   = 2'd3
    } t_op;

    // One job per input that causes results: the window it sees and the
    // sequence of operations to run on it.
    typedef struct packed {
        t_sample [WIN_N-1:0] win;
        t_op                 first_op;
        logic                has_right;
        logic [IDX_W-1:0]    base_idx;
    } t_job;

endpackage

// ----- sv/w26ra_front.sv -----
// Front end: sample window, column count and job classification.
// Depends on w26ra_pkg.
module w26ra_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  w26ra_pkg::t_in_item i_in_data,
    input  logic              i_job_full,
    output logic              o_job_wr,
    output w26ra_pkg::t_job   o_job
);
    import w26ra_pkg::*;

    t_sample [WIN_N-1:0] r_win;
    t_sample [WIN_N-1:0] n_win;
    logic [COL_W-1:0]    r_col;
    logic [COL_W-1:0]    n_col;
    logic                accept;
    logic                row_end;
    logic [IDX_W-1:0]    half_m1;

    always_comb begin
        accept  = i_push && !i_job_full;
        row_end = i_in_data.row_end || (r_col == COL_LAST);
        half_m1 = IDX_W'(r_col[COL_W-1:1]) - IDX_W'(1);
        n_win   = {i_in_data.sample, r_win[WIN_N-1:1]};
        n_col   = row_end ? '0 : r_col + COL_W'(1);

        o_job.win       = n_win;
        o_job.first_op  = OP_INNER;
        o_job.has_right = row_end;
        o_job.base_idx  = half_m1;
        o_job_wr        = 1'b0;

        if (row_end && (r_col < COL_FIRST_PAIR)) begin
            o_job.first_op  = OP_ERR;
            o_job.has_right = 1'b0;
            o_job.base_idx  = '0;
            o_job_wr        = accept;
        end else if (r_col[0]) begin
            if (r_col == COL_FIRST_PAIR) begin
                o_job.first_op = OP_LEFT;
                o_job.base_idx = '0;
                o_job_wr       = accept;
            end else if (r_col > COL_FIRST_PAIR) begin
                o_job_wr = accept;
            end
        end else if (row_end) begin
            // Odd width: the last sample is repeated past the right edge.
            o_job.win       = {n_win[WIN_N-1], n_win[WIN_N-1:1]};
            o_job.has_right = 1'b1;
            o_job_wr        = accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else if (accept) begin
            r_col <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_win <= n_win;
        end
    end

endmodule

// ----- sv/w26ra_job_queue.sv -----
// Short queue of jobs between the front end and the filter back end.
// Depends on w26ra_pkg.
module w26ra_job_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  w26ra_pkg::t_job i_wr_data,
    input  logic            i_rd,
    output w26ra_pkg::t_job o_rd_data,
    output logic            o_full,
    output logic            o_empty
);
    import w26ra_pkg::*;

    t_job                r_mem [JOBQ_DEPTH];
    logic [JOBQ_AW-1:0]  r_wr_ptr;
    logic [JOBQ_AW-1:0]  r_rd_ptr;
    logic [JOBQ_AW:0]    r_cnt;
    logic                do_wr;
    logic                do_rd;

    always_comb begin
        o_full    = (r_cnt == (JOBQ_AW+1)'(JOBQ_DEPTH));
        o_empty   = (r_cnt == '0);
        do_wr     = i_wr && !o_full;
        do_rd     = i_rd && !o_empty;
        o_rd_data = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= r_wr_ptr + JOBQ_AW'(1);
            end
            if (do_rd) begin
                r_rd_ptr <= r_rd_ptr + JOBQ_AW'(1);
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + (JOBQ_AW+1)'(1);
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - (JOBQ_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

// ----- sv/w26ra_back.sv -----
// Back end: issues the filter operations of each job, runs the three-stage
// filter pipeline and holds finished results. Depends on w26ra_pkg.
module w26ra_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [w26ra_pkg::SHIFT_W-1:0] i_cfg_data,
    input  w26ra_pkg::t_job            i_job,
    input  logic                       i_job_empty,
    output logic                       o_job_rd,
    input  logic                       i_pop,
    output logic                       o_empty,
    output w26ra_pkg::t_out_item       o_out_data
);
    import w26ra_pkg::*;

    logic [SHIFT_W-1:0] r_shift;
    logic [RND_W-1:0]   rnd;

    // Dispatch
    logic [1:0]         r_k;
    t_op                cur_op;
    logic               cur_last;
    logic               room;
    logic               issue;

    // Stage A: prescale
    logic signed [SAMPLE_W:0]   ext [WIN_N];
    t_sample [WIN_N-1:0]        pre;
    t_sample                    lo_a;
    t_sample                    lo_b;
    logic signed [SAMPLE_W+1:0] lsum;
    logic                       r_a_valid;
    t_sample [WIN_N-1:0]        r_a_pre;
    t_sample                    r_a_low;
    t_op                        r_a_op;
    logic [IDX_W-1:0]           r_a_idx;
    logic                       r_a_last;

    // Stage B: weighted sum
    logic signed [ACC_W-1:0] q [WIN_N];
    logic signed [ACC_W-1:0] sum;
    logic signed [ACC_W-1:0] diff;
    logic                    r_b_valid;
    logic signed [ACC_W-1:0] r_b_sum;
    logic signed [ACC_W-1:0] r_b_diff;
    t_sample                 r_b_low;
    t_op                     r_b_op;
    logic [IDX_W-1:0]        r_b_idx;
    logic                    r_b_last;

    // Stage C: scale, clamp, result queue
    logic signed [ACC_W-1:0] hp;
    t_sample                 hp_clamped;
    t_out_item               res;
    t_out_item               r_oq [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]      r_oq_wr;
    logic [OUTQ_AW-1:0]      r_oq_rd;
    logic [OUTQ_AW:0]        r_oq_cnt;
    logic                    oq_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift <= '0;
        end else if (i_cfg_valid) begin
            r_shift <= i_cfg_data;
        end
    end

    // Each issued operation holds a slot in the result queue until popped,
    // so the pipeline never has to stall once an operation is in flight.
    always_comb begin
        rnd      = RND_W'((4'd1 << r_shift) - 4'd1);
        cur_op   = (i_job.first_op == OP_ERR) ? OP_ERR
                                              : t_op'(2'(i_job.first_op) + r_k);
        cur_last = (cur_op == OP_ERR) || (cur_op == OP_RIGHT)
                || ((cur_op == OP_INNER) && !i_job.has_right);
        room     = ((OUTQ_AW+2)'(r_oq_cnt) + (OUTQ_AW+2)'(r_a_valid)
                  + (OUTQ_AW+2)'(r_b_valid)) < (OUTQ_AW+2)'(OUTQ_DEPTH);
        issue    = !i_job_empty && room;
        o_job_rd = issue && cur_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (issue) begin
            r_k <= cur_last ? 2'd0 : r_k + 2'd1;
        end
    end

    always_comb begin
        for (int k = 0; k < WIN_N; k++) begin
            ext[k] = (SAMPLE_W+1)'($signed(i_job.win[k])) + (SAMPLE_W+1)'(rnd);
            pre[k] = SAMPLE_W'(ext[k] >>> r_shift);
        end
        case (cur_op)
            OP_LEFT: begin
                lo_a = i_job.win[0];
                lo_b = i_job.win[1];
            end
            OP_RIGHT: begin
                lo_a = i_job.win[4];
                lo_b = i_job.win[5];
            end
            default: begin
                lo_a = i_job.win[2];
                lo_b = i_job.win[3];
            end
        endcase
        lsum = (SAMPLE_W+2)'($signed(lo_a)) + (SAMPLE_W+2)'($signed(lo_b))
             + (SAMPLE_W+2)'(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_a_pre  <= pre;
            r_a_low  <= SAMPLE_W'(lsum >>> r_shift);
            r_a_op   <= cur_op;
            r_a_idx  <= i_job.base_idx + IDX_W'(r_k);
            r_a_last <= cur_last;
        end
    end

    // Border taps are 5,-11,4,4,-1,-1 and their negated mirror; inside the
    // row the outer taps are scaled by 1/8 before the center difference is added.
    always_comb begin
        for (int k = 0; k < WIN_N; k++) begin
            q[k] = ACC_W'($signed(r_a_pre[k]));
        end
        case (r_a_op)
            OP_LEFT: begin
                sum  = (q[0] <<< 2) + q[0] - (q[1] <<< 3) - (q[1] <<< 1) - q[1]
                     + (q[2] <<< 2) + (q[3] <<< 2) - q[4] - q[5] + HP_ROUND;
                diff = '0;
            end
            OP_INNER: begin
                sum  = q[4] + q[5] - q[0] - q[1] + HP_ROUND;
                diff = q[2] - q[3];
            end
            OP_RIGHT: begin
                sum  = q[0] + q[1] - (q[2] <<< 2) - (q[3] <<< 2)
                     + (q[4] <<< 3) + (q[4] <<< 1) + q[4]
                     - (q[5] <<< 2) - q[5] + HP_ROUND;
                diff = '0;
            end
            default: begin
                sum  = '0;
                diff = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_b_sum  <= sum;
            r_b_diff <= diff;
            r_b_low  <= r_a_low;
            r_b_op   <= r_a_op;
            r_b_idx  <= r_a_idx;
            r_b_last <= r_a_last;
        end
    end

    always_comb begin
        hp = (r_b_sum >>> HP_SHIFT) + r_b_diff;
        if (hp > HP_MAX) begin
            hp_clamped = SAMPLE_W'(HP_MAX);
        end else if (hp < HP_MIN) begin
            hp_clamped = SAMPLE_W'(HP_MIN);
        end else begin
            hp_clamped = SAMPLE_W'(hp);
        end
        if (r_b_op == OP_ERR) begin
            res.low_coef   = '0;
            res.high_coef  = '0;
            res.coef_index = '0;
            res.row_done   = 1'b1;
            res.run_last   = 1'b1;
            res.row_error  = 1'b1;
        end else begin
            res.low_coef   = r_b_low;
            res.high_coef  = hp_clamped;
            res.coef_index = r_b_idx;
            res.row_done   = (r_b_op == OP_RIGHT);
            res.run_last   = r_b_last;
            res.row_error  = 1'b0;
        end
        o_empty    = (r_oq_cnt == '0);
        oq_pop     = i_pop && !o_empty;
        o_out_data = r_oq[r_oq_rd];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oq_wr  <= '0;
            r_oq_rd  <= '0;
            r_oq_cnt <= '0;
        end else begin
            if (r_b_valid) begin
                r_oq_wr <= r_oq_wr + OUTQ_AW'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OUTQ_AW'(1);
            end
            if (r_b_valid && !oq_pop) begin
                r_oq_cnt <= r_oq_cnt + (OUTQ_AW+1)'(1);
            end else if (oq_pop && !r_b_valid) begin
                r_oq_cnt <= r_oq_cnt - (OUTQ_AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_oq[r_oq_wr] <= res;
        end
    end

endmodule

// ----- sv/wavelet_2_6_row_analysis_core.sv -----
// 2/6 wavelet forward horizontal analysis of one image row.
// Samples go in through a queue-like port (push/full): one signed sample per
// accepted push, with row_end on the last sample of the row. Coefficient
// pairs come out through a queue-like port (empty/pop): the oldest result is
// on o_out_data while empty is low and leaves when pop is high.
// The prescale shift must be written on the cfg channel (always ready) between
// rows while the block is idle; the block itself does not enforce this.
// Throughput: one sample per cycle sustained while the receiver pops. The filter
// back end produces one coefficient pair per cycle while the result queue has
// room; the two or three pairs that the sixth sample or an odd row end causes
// are absorbed by a four-entry job queue. A result goes from the job queue
// through the stage A and B registers to the result queue and the output.
// When the receiver stalls, the four-entry result queue fills, the back end
// stops issuing, the job queue fills and full rises.
// Reset (synchronous, active low) empties both queues, clears the column
// count and sets the prescale shift to zero.
// Depends on w26ra_pkg, w26ra_front, w26ra_job_queue and w26ra_back.
module wavelet_2_6_row_analysis_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  w26ra_pkg::t_in_item           i_in_data,
    output logic                          empty,
    input  logic                          pop,
    output w26ra_pkg::t_out_item          o_out_data,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [w26ra_pkg::SHIFT_W-1:0] i_cfg_data
);
    import w26ra_pkg::*;

    logic job_wr;
    logic job_rd;
    logic job_full;
    logic job_empty;
    t_job job_in;
    t_job job_head;

    assign full = job_full;

    w26ra_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_in_data  (i_in_data),
        .i_job_full (job_full),
        .o_job_wr   (job_wr),
        .o_job      (job_in)
    );

    w26ra_job_queue u_job_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (job_wr),
        .i_wr_data (job_in),
        .i_rd      (job_rd),
        .o_rd_data (job_head),
        .o_full    (job_full),
        .o_empty   (job_empty)
    );

    w26ra_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_job       (job_head),
        .i_job_empty (job_empty),
        .o_job_rd    (job_rd),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_out_data  (o_out_data)
    );

endmodule

// ----- bench/tb_wavelet_2_6_row_analysis_core.sv -----
// Self-checking testbench for wavelet_2_6_row_analysis_core: rows of samples go in,
// and every coefficient pair that comes out is compared with an in-bench filter model.
// Depends on w26ra_pkg and the core RTL only.
module tb_wavelet_2_6_row_analysis_core;
    import w26ra_pkg::*;

    localparam int  RANDOM_ITEMS = 260;
    localparam int  DRAIN_CYCLES = 8;
    localparam int  MAX_REPORTS  = 30;
    localparam time RUN_LIMIT    = 10_000_000;

    // Sample styles for generated rows.
    localparam int STY_FULL    = 0;
    localparam int STY_SMALL   = 1;
    localparam int STY_EXTREME = 2;
    localparam int STY_NEAR    = 3;

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                push        = 1'b0;
    logic                full;
    t_in_item            i_in_data   = '0;
    logic                empty;
    logic                pop         = 1'b0;
    t_out_item           o_out_data;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [SHIFT_W-1:0]  i_cfg_data  = '0;

    // Filter model state.
    int        row_win [WIN_N];
    int        col_count;
    int        pre_shift;
    t_out_item pending_pairs [$];

    int err_count     = 0;
    int items_sent    = 0;
    int pairs_checked = 0;
    int short_rows    = 0;

    // Sender burst control.
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // Receiver stall pattern.
    bit rx_stall_en   = 1'b0;
    int rx_max_stall  = 6;
    bit rx_stalling   = 1'b0;
    int rx_left       = 0;

    wavelet_2_6_row_analysis_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in_data   (i_in_data),
        .empty       (empty),
        .pop         (pop),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #(RUN_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ---------------- filter model ----------------

    function automatic int prescaled(int x);
        return (x + ((1 << pre_shift) - 1)) >>> pre_shift;
    endfunction

    function automatic t_sample lowpass(int a, int b);
        int v;
        v = (a + b + ((1 << pre_shift) - 1)) >>> pre_shift;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic t_sample clamp_hp(int v);
        int c;
        c = v;
        if (c > 32767) c = 32767;
        if (c < -32768) c = -32768;
        return c[SAMPLE_W-1:0];
    endfunction

    function automatic t_sample hp_left(int w0, int w1, int w2, int w3, int w4, int w5);
        int s;
        s = 5 * prescaled(w0) - 11 * prescaled(w1) + 4 * prescaled(w2) + 4 * prescaled(w3)
            - prescaled(w4) - prescaled(w5) + 4;
        return clamp_hp(s >>> HP_SHIFT);
    endfunction

    function automatic t_sample hp_inner(int a, int b, int c, int d, int e, int f);
        int s;
        s = -prescaled(a) - prescaled(b) + prescaled(e) + prescaled(f) + 4;
        s = (s >>> HP_SHIFT) + prescaled(c) - prescaled(d);
        return clamp_hp(s);
    endfunction

    // nx is the sample past the border column c0; m1..m4 lie before it.
    function automatic t_sample hp_right(int nx, int c0, int m1, int m2, int m3, int m4);
        int s;
        s = -5 * prescaled(nx) + 11 * prescaled(c0) - 4 * prescaled(m1) - 4 * prescaled(m2)
            + prescaled(m3) + prescaled(m4) + 4;
        return clamp_hp(s >>> HP_SHIFT);
    endfunction

    function automatic t_out_item make_pair(t_sample lo, t_sample hi, int idx,
                                            logic done, logic err);
        t_out_item r;
        r.low_coef   = lo;
        r.high_coef  = hi;
        r.coef_index = idx[IDX_W-1:0];
        r.row_done   = done;
        r.run_last   = 1'b0;
        r.row_error  = err;
        return r;
    endfunction

    task automatic predict_pairs(t_in_item it);
        t_out_item res [3];
        int        n;
        int        c;
        bit        at_end;
        n      = 0;
        c      = col_count;
        at_end = it.row_end || (c + 1 >= MAX_ROW_WIDTH);
        for (int k = 0; k < WIN_N - 1; k++) row_win[k] = row_win[k + 1];
        row_win[WIN_N - 1] = int'(it.sample);

        if (at_end && c < 5) begin
            res[n] = make_pair('0, '0, 0, 1'b1, 1'b1);
            n = n + 1;
            short_rows++;
        end else if (c % 2 == 1) begin
            if (c == 5) begin
                res[n] = make_pair(lowpass(row_win[0], row_win[1]),
                    hp_left(row_win[0], row_win[1], row_win[2], row_win[3], row_win[4],
                            row_win[5]), 0, 1'b0, 1'b0);
                n = n + 1;
            end
            if (c >= 5) begin
                res[n] = make_pair(lowpass(row_win[2], row_win[3]),
                    hp_inner(row_win[0], row_win[1], row_win[2], row_win[3], row_win[4],
                             row_win[5]), (c - 3) / 2, 1'b0, 1'b0);
                n = n + 1;
            end
            if (at_end) begin
                res[n] = make_pair(lowpass(row_win[4], row_win[5]),
                    hp_right(row_win[5], row_win[4], row_win[3], row_win[2], row_win[1],
                             row_win[0]), (c - 1) / 2, 1'b1, 1'b0);
                n = n + 1;
            end
        end else if (at_end) begin
            // Odd width: the last sample stands in for the missing one.
            res[n] = make_pair(lowpass(row_win[3], row_win[4]),
                hp_inner(row_win[1], row_win[2], row_win[3], row_win[4], row_win[5],
                         row_win[5]), (c - 2) / 2, 1'b0, 1'b0);
            n = n + 1;
            res[n] = make_pair(lowpass(row_win[5], row_win[5]),
                hp_right(row_win[5], row_win[5], row_win[4], row_win[3], row_win[2],
                         row_win[1]), c / 2, 1'b1, 1'b0);
            n = n + 1;
        end

        if (n > 0) res[n - 1].run_last = 1'b1;
        for (int k = 0; k < n; k++) pending_pairs.push_back(res[k]);
        col_count = at_end ? 0 : c + 1;
    endtask

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, int got, int want);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("mismatch at pair %0d: %s got %0d want %0d",
                     pairs_checked, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin : rx_side
        t_out_item want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (pending_pairs.size() == 0) begin
                    report_mismatch("unexpected pair, index", int'(o_out_data.coef_index), -1);
                end else begin
                    want = pending_pairs.pop_front();
                    if (o_out_data.low_coef !== want.low_coef)
                        report_mismatch("low_coef", o_out_data.low_coef, want.low_coef);
                    if (o_out_data.high_coef !== want.high_coef)
                        report_mismatch("high_coef", o_out_data.high_coef, want.high_coef);
                    if (o_out_data.coef_index !== want.coef_index)
                        report_mismatch("coef_index", o_out_data.coef_index, want.coef_index);
                    if (o_out_data.row_done !== want.row_done)
                        report_mismatch("row_done", o_out_data.row_done, want.row_done);
                    if (o_out_data.run_last !== want.run_last)
                        report_mismatch("run_last", o_out_data.run_last, want.run_last);
                    if (o_out_data.row_error !== want.row_error)
                        report_mismatch("row_error", o_out_data.row_error, want.row_error);
                    pairs_checked++;
                end
            end
            // Alternate runs of pops and stalls of random length.
            if (rx_left == 0) begin
                rx_stalling = !rx_stalling;
                rx_left = rx_stalling ? $urandom_range(1, rx_max_stall) : $urandom_range(1, 10);
            end
            rx_left--;
            pop <= !(rx_stall_en && rx_stalling);
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_sample(t_sample s, logic last);
        t_in_item it;
        int       gap;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left > 0) burst_left--;
        it.sample  = s;
        it.row_end = last;
        push      <= 1'b1;
        i_in_data <= it;
        do @(posedge i_clk); while (full);
        predict_pairs(it);
        items_sent++;
    endtask

    // Hold the sender until every predicted pair has come out, then let the
    // pipeline settle in case the last sample caused no pair.
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_shift(int value);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value[SHIFT_W-1:0];
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        pre_shift = value;
    endtask

    function automatic t_sample pick_sample(int style);
        logic [31:0] r;
        r = $urandom;
        case (style)
            STY_SMALL:   return t_sample'(int'($urandom_range(0, 64)) - 32);
            STY_EXTREME: begin
                case (r[1:0])
                    2'd0:    return 16'sh7fff;
                    2'd1:    return 16'sh8000;
                    2'd2:    return 16'sh0000;
                    default: return 16'shffff;
                endcase
            end
            STY_NEAR:    return r[31] ? t_sample'(16'sh7fff - r[7:0])
                                      : t_sample'(16'sh8000 + r[7:0]);
            default:     return r[SAMPLE_W-1:0];
        endcase
    endfunction

    task automatic send_row(int width, int style, bit with_end);
        for (int c = 0; c < width; c++) begin
            send_sample(pick_sample(style), with_end && (c == width - 1));
        end
    endtask

    // ---------------- tests ----------------

    // Short rows, clamping with alternating full-scale samples, and an odd width.
    task automatic test_directed_rows();
        gaps_on = 1'b0;
        write_shift(0);
        send_sample(16'sh8000, 1'b1);
        send_sample(16'sh7fff, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0000, 1'b0);
        send_sample(16'shffff, 1'b0);
        send_sample(16'sh0001, 1'b1);
        for (int c = 0; c < 6; c++) begin
            send_sample((c % 2) ? 16'sh8000 : 16'sh7fff, c == 5);
        end
        for (int c = 0; c < 7; c++) begin
            send_sample((c % 2) ? 16'sh7fff : 16'sh8000, c == 6);
        end
    endtask

    task automatic test_random_rows();
        int shifts [4] = '{1, 3, 0, 2};
        int quota;
        int width;
        int pick;
        foreach (shifts[k]) begin
            write_shift(shifts[k]);
            quota = items_sent + RANDOM_ITEMS / 4;
            while (items_sent < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 12)      width = $urandom_range(1, 5);
                else if (pick < 17) width = $urandom_range(41, 120);
                else                width = $urandom_range(6, 40);
                gaps_on      = ($urandom_range(0, 3) != 0);
                rx_stall_en  = ($urandom_range(0, 2) != 0);
                rx_max_stall = $urandom_range(1, 12);
                send_row(width, $urandom_range(STY_FULL, STY_NEAR), 1'b1);
            end
        end
    endtask

    // Heavy receiver stalls against a sender with no gaps; one pause mid-row.
    task automatic test_backpressure();
        write_shift(3);
        gaps_on      = 1'b0;
        rx_stall_en  = 1'b1;
        rx_max_stall = 20;
        send_row(17, STY_FULL, 1'b0);
        wait_drained();
        send_row(23, STY_FULL, 1'b1);
        send_row(31, STY_NEAR, 1'b1);
    endtask

    initial begin
        for (int k = 0; k < WIN_N; k++) row_win[k] = 0;
        col_count = 0;
        pre_shift = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_rows();
        test_random_rows();
        test_backpressure();

        push <= 1'b0;
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES * 2) @(posedge i_clk);

        $display("summary: %0d samples in, %0d coefficient pairs compared, %0d short rows,",
                 items_sent, pairs_checked, short_rows);
        $display("summary: prescale 0 to 3, odd and even widths, stalls and a mid-row pause");
        if (err_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/w26ra_pkg.sv
sv/w26ra_front.sv
sv/w26ra_job_queue.sv
sv/w26ra_back.sv
sv/wavelet_2_6_row_analysis_core.sv
bench/tb_wavelet_2_6_row_analysis_core.sv
